>>> rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and codes of the max-priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SCOUNT_W = 4;

    // request operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    load_result;
        logic    do_insert;
        logic    do_remove;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  req_op;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

>>> rtl/core/mpq_if.sv
// ----------------------------------------------------------------------------
// mpq request and result channels
// valid/ready channels carrying one request or one result
// ----------------------------------------------------------------------------
interface mpq_req_if;
    import mpq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mpq_rsp_if;
    import mpq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [SCOUNT_W-1:0]       stored_count;

    modport source (output valid, output status, output removed_value,
                    output stored_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input stored_count, output ready);
endinterface

>>> rtl/core/mpq_datapath.sv
// ----------------------------------------------------------------------------
// mpq_datapath
// sorted chain of value cells, request capture and result register
// ----------------------------------------------------------------------------
module mpq_datapath #(
    parameter int CAPACITY = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mpq_pkg::t_cmd                      i_cmd,
    output mpq_pkg::t_dp_stat                  o_stat,
    input  logic                               i_operation,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_value,
    output logic [mpq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [mpq_pkg::VALUE_W-1:0] o_removed_value,
    output logic [mpq_pkg::SCOUNT_W-1:0]       o_stored_count
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > SCOUNT_W) ? CNT_W : SCOUNT_W;

    // captured request
    t_op                      r_op;
    logic signed [VALUE_W-1:0] r_val;

    // cells kept in descending order, maximum in cell 0
    logic signed [VALUE_W-1:0] r_entry [CAPACITY];
    logic signed [VALUE_W-1:0] n_entry [CAPACITY];
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CAPACITY-1:0]       keep;
    logic [EXT_W-1:0]          count_ext;

    // result register
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_removed;
    logic [SCOUNT_W-1:0]       r_stored;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_operation);
            r_val <= i_value;
        end
    end

    // a cell keeps its value when it is occupied and not below the new one
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (CNT_W'(i) < r_count) && (r_entry[i] >= r_val);
        end
    end

    // next cell contents for either operation
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.do_remove) begin
                n_entry[i] = (i < CAPACITY - 1) ? r_entry[(i + 1) % CAPACITY] : r_entry[i];
            end else if (keep[i]) begin
                n_entry[i] = r_entry[i];
            end else if (i == 0) begin
                n_entry[i] = r_val;
            end else if (keep[(i + CAPACITY - 1) % CAPACITY]) begin
                n_entry[i] = r_val;
            end else begin
                n_entry[i] = r_entry[(i + CAPACITY - 1) % CAPACITY];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
        count_ext = EXT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert || i_cmd.do_remove) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_status  <= i_cmd.status;
            r_removed <= i_cmd.do_remove ? r_entry[0] : '0;
            r_stored  <= count_ext[SCOUNT_W-1:0];
        end
    end

    assign o_stat.req_op   = r_op;
    assign o_stat.full     = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty    = (r_count == '0);
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_stored_count  = r_stored;

endmodule

>>> rtl/core/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// request sequencing, outcome decision and result valid flag
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  mpq_pkg::t_dp_stat i_stat,
    output mpq_pkg::t_cmd     o_cmd
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                    if (i_stat.req_op == OP_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_OVERFLOW;
                        end else begin
                            o_cmd.do_insert = 1'b1;
                            o_cmd.status    = ST_INSERTED;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_UNDERFLOW;
                        end else begin
                            o_cmd.do_remove = 1'b1;
                            o_cmd.status    = ST_REMOVED;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_result;
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// bounded max-priority queue over a sorted chain of cells
// ----------------------------------------------------------------------------
// Each request either inserts a signed 32-bit value or removes the largest
// stored value, and gives exactly one result: status, the removed value
// (zero unless the status is removed) and the count held afterwards, shown
// modulo 16. An insert into a full queue reports overflow and a remove from
// an empty one reports underflow; neither changes the contents. Each
// request is first captured; then, once the result register is free, all
// cells of the sorted chain compare against the new value in parallel and
// shift by one place, writing the result register. A new request is taken
// while the last result still waits on the output, but not while one is
// still being executed.
module max_priority_queue #(
    parameter int CAPACITY = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mpq_req_if.sink   i_req,
    mpq_rsp_if.source o_rsp
);
    import mpq_pkg::*;

    t_cmd     cmd;
    t_dp_stat dp_stat;

    // sequencing of each request
    mpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (dp_stat),
        .o_cmd       (cmd)
    );

    // value cells, count and result register
    mpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (dp_stat),
        .i_operation     (i_req.operation),
        .i_value         (i_req.value),
        .o_status        (o_rsp.status),
        .o_removed_value (o_rsp.removed_value),
        .o_stored_count  (o_rsp.stored_count)
    );

endmodule

>>> rtl/core/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// port-level checks of the max-priority queue
// ----------------------------------------------------------------------------
module mpq_checker #(
    parameter int CAPACITY = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [mpq_pkg::STATUS_W-1:0]       i_status,
    input logic signed [mpq_pkg::VALUE_W-1:0] i_removed_value,
    input logic [mpq_pkg::SCOUNT_W-1:0]       i_stored_count
);
    import mpq_pkg::*;

    localparam logic [SCOUNT_W-1:0] CAP_SHOWN = SCOUNT_W'(CAPACITY);

    // removed value only carries data on a removal
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_REMOVED) |-> (i_removed_value == '0))
        else $error("removed value not zero");

    // underflow only from an empty queue
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_UNDERFLOW) |-> (i_stored_count == '0))
        else $error("underflow with non-zero count");

    // overflow only from a full queue
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_OVERFLOW) |-> (i_stored_count == CAP_SHOWN))
        else $error("overflow below capacity");

    // a stalled result keeps its valid, status and count
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_stored_count)))
        else $error("stalled result changed");

endmodule

bind max_priority_queue mpq_checker #(
    .CAPACITY (CAPACITY)
) u_mpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_removed_value (o_rsp.removed_value),
    .i_stored_count  (o_rsp.stored_count)
);
